// ----- src/assert_macros.svh -----
// Assertion macros shared by the row engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LGRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lgre check failed");

// Next-cycle implication, held off during reset.
`define LGRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lgre check failed");

`endif

// ----- src/lgre_pkg.sv -----
// Shared types and constants for the Life generation row engine.
package lgre_pkg;

	localparam int ROW_W         = 64;
	localparam int ROW_CELLS_DEF = 64;
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;
	localparam int COUNT_W       = 4;

	// which three rows form the 3x3 window of a column
	typedef enum logic [1:0] {
		WIN_STORED_ROW  = 2'd0, // upper, middle, incoming row
		WIN_STORED_DEAD = 2'd1, // upper, middle, dead row below
		WIN_FRESH       = 2'd2  // middle (dead), incoming row, dead row below
	} win_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		win_sel_t sel;
	} cell_ctrl_t;

	// one column of the window: above, here, below
	typedef struct packed {
		logic a;
		logic h;
		logic b;
	} col_t;

	typedef struct packed {
		logic [ROW_W-1:0] next_cells;
		logic             board_done;
	} result_t;

endpackage

// ----- src/lgre_cell.sv -----
// One column cell: holds two stored row bits and applies the B3/S23 rule.
module lgre_cell
	import lgre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       row_bit,
	input  col_t       left,
	input  col_t       right,
	output col_t       win,
	output logic       next_bit
);

	logic                upper_q;
	logic                middle_q;
	logic [COUNT_W-1:0]  count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctrl.clear) begin
			upper_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctrl.load) begin
			upper_q  <= middle_q;
			middle_q <= row_bit;
		end
	end

	always_comb begin
		case (ctrl.sel)
			WIN_STORED_ROW:  win = '{a: upper_q, h: middle_q, b: row_bit};
			WIN_STORED_DEAD: win = '{a: upper_q, h: middle_q, b: 1'b0};
			WIN_FRESH:       win = '{a: middle_q, h: row_bit, b: 1'b0};
			default:         win = '0;
		endcase
	end

	assign count = COUNT_W'(left.a) + COUNT_W'(left.h) + COUNT_W'(left.b)
		+ COUNT_W'(right.a) + COUNT_W'(right.h) + COUNT_W'(right.b)
		+ COUNT_W'(win.a) + COUNT_W'(win.b);

	assign next_bit = (count == COUNT_W'(BIRTH_COUNT))
		|| ((count == COUNT_W'(SURVIVE_COUNT)) && win.h);

endmodule

// ----- src/lgre_outbuf.sv -----
// Output register plus skid entry for result transactions.
`include "assert_macros.svh"

module lgre_outbuf
	import lgre_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LGRE_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`LGRE_ASSERT_NOW(a_no_push_when_full, clk, arst_n, skid_valid_q, !push)

endmodule

// ----- src/life_generation_row_engine_top.sv -----
// Top level of the Life (B3/S23) generation row engine.
//
// Usage:
//  - Input channel (in_valid/in_ready): one board row per transaction, top row
//    first; row_cells bit k is column k, final_row marks the bottom row.
//  - Output channel (out_valid/out_ready): next generation of one row per
//    transaction; board_done is set on the bottom row's result.
//  - A row held in the cells yields its result when the row below arrives; the
//    result is registered in the output register, or the skid entry on a stall.
//  - Throughput: one row per cycle while in_ready is high. A bottom row that
//    follows a held row gives two results; the second comes from the cells
//    while flush_q is set, during which in_ready is low (a bubble per board).
//  - Cells outside the board are dead; column bits at or above ROW_CELLS are
//    ignored on input and read as zero on output.
//  - Stall: the output register plus one skid entry absorb one extra result;
//    in_ready drops only while the skid entry is occupied or the bottom-row
//    flush is pending.
//  - Reset (arst_n low): stored rows clear, no row held, output empty.
//  - Datapath: a chain of ROW_CELLS column cells, each storing the upper and
//    middle bit of its column and sharing its 3-bit window with both neighbors.
`include "assert_macros.svh"

module life_generation_row_engine_top
	import lgre_pkg::*;
#(
	parameter int ROW_CELLS = ROW_CELLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ROW_W-1:0] row_cells,
	input  logic             final_row,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ROW_W-1:0] next_cells,
	output logic             board_done
);

	logic                 present_q;   // cells hold a row awaiting its result
	logic                 flush_q;     // bottom row loaded, its own result pending
	logic                 skid_full;
	logic                 in_fire;
	logic                 flush_fire;
	logic                 produce;
	cell_ctrl_t           ctrl;
	col_t                 win [ROW_CELLS];
	logic [ROW_CELLS-1:0] next_bits;
	result_t              new_result;
	result_t              out_data;

	assign in_ready   = !flush_q && !skid_full;
	assign in_fire    = in_valid && in_ready;
	assign flush_fire = flush_q && !skid_full;

	// A result comes out of a row below a held row, a lone bottom row, or the flush.
	assign produce = flush_fire || (in_fire && (present_q || final_row));

	always_comb begin
		ctrl.load  = in_fire && !(final_row && !present_q);
		ctrl.clear = (in_fire && final_row && !present_q) || flush_fire;
		if (flush_q) begin
			ctrl.sel = WIN_STORED_DEAD;
		end else if (present_q) begin
			ctrl.sel = WIN_STORED_ROW;
		end else begin
			ctrl.sel = WIN_FRESH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			flush_q   <= 1'b0;
		end else if (flush_fire) begin
			present_q <= 1'b0;
			flush_q   <= 1'b0;
		end else if (in_fire) begin
			present_q <= !final_row;
			flush_q   <= final_row && present_q;
		end
	end

	// chain of column cells; off-board neighbors are dead
	genvar k;
	generate
		for (k = 0; k < ROW_CELLS; k++) begin : g_col
			col_t left_win;
			col_t right_win;

			if (k == 0) begin : g_left_edge
				assign left_win = '0;
			end else begin : g_left
				assign left_win = win[k-1];
			end

			if (k == ROW_CELLS - 1) begin : g_right_edge
				assign right_win = '0;
			end else begin : g_right
				assign right_win = win[k+1];
			end

			lgre_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.row_bit  (row_cells[k]),
				.left     (left_win),
				.right    (right_win),
				.win      (win[k]),
				.next_bit (next_bits[k])
			);
		end
	endgenerate

	assign new_result.next_cells = ROW_W'(next_bits);
	assign new_result.board_done = flush_q || (final_row && !present_q);

	lgre_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (produce),
		.push_data (new_result),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign next_cells = out_data.next_cells;
	assign board_done = out_data.board_done;

	`LGRE_ASSERT_NOW(a_flush_blocks_input, clk, arst_n, flush_q, !in_ready)
	`LGRE_ASSERT_NOW(a_flush_has_row, clk, arst_n, flush_q, !present_q)
	`LGRE_ASSERT_NEXT(a_bottom_after_held, clk, arst_n,
		in_fire && final_row && present_q, flush_q)
	`LGRE_ASSERT_NEXT(a_flush_clears, clk, arst_n, flush_fire, !flush_q && !present_q)

endmodule
